FILE: rtl/persistent_counter_bad_byte_remap_core_defines.svh
// Assertion macros for the persistent counter bad-byte remap core.
`ifndef PERSISTENT_COUNTER_BAD_BYTE_REMAP_CORE_DEFINES_SVH
`define PERSISTENT_COUNTER_BAD_BYTE_REMAP_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication check.
`define PCBBR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
// Next-cycle implication check.
`define PCBBR_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define PCBBR_ASSERT_IMP(label, clk, rst, ante, cons)
`define PCBBR_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/pcbbr_pkg.sv
// Package: types, codes and default sizes for the persistent counter core.
`timescale 1ns / 1ps
`default_nettype none
package pcbbr_pkg;

  // default sizes
  localparam int NUM_COUNTERS_DEF   = 4;
  localparam int BYTES_PER_COPY_DEF = 16;
  localparam int VALUE_BYTES_DEF    = 4;

  // copies per counter, rotated on each increment
  localparam int NUM_COPIES = 3;
  // positions at or above this never fail a write
  localparam int FAIL_BITS  = 16;

  // operation codes
  typedef enum logic [1:0] {
    FN_GET = 2'd0,
    FN_INC = 2'd1,
    FN_CLR = 2'd2
  } func_t;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_SHORT = 2'd1,
    STAT_MASK  = 2'd2
  } stat_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_SCAN,
    S_RD_WAIT,
    S_INC,
    S_CNT,
    S_WR_SCAN,
    S_WR_CMP,
    S_CLR,
    S_FINISH
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/pcbbr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module pcbbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 192,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/persistent_counter_bad_byte_remap_core.sv
// Get: a read walk over the active copy that skips bad positions, then the result.
// Increment: read walk, add step, count of good bytes in the next copy, then a
//   write walk that compares each byte and tries to rewrite only those that differ.
// Counter clear: zeroes every byte of the selected counter's copies. One item at a time through one byte RAM port.
// Reset (rst, sync, high): sequencer idle, active copies zero; counter bytes and
//   masks are undefined until a counter clear. Results are a one-cycle done strobe.
`timescale 1ns / 1ps
`default_nettype none
`include "persistent_counter_bad_byte_remap_core_defines.svh"
module persistent_counter_bad_byte_remap_core
  import pcbbr_pkg::*;
#(
  parameter int NUM_COUNTERS   = NUM_COUNTERS_DEF,
  parameter int BYTES_PER_COPY = BYTES_PER_COPY_DEF,
  parameter int VALUE_BYTES    = VALUE_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  func,
  input  wire logic [1:0]  counter_sel,
  input  wire logic [15:0] fail_positions,
  input  wire logic        mask_write_fails,
  output logic             done,
  output logic [31:0]      value,
  output logic [1:0]       status
);

  localparam int NSLOTS = NUM_COUNTERS * NUM_COPIES;
  localparam int DEPTH  = NSLOTS * BYTES_PER_COPY;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SLOT_W = $clog2(NSLOTS);
  localparam int CNT_W  = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;
  localparam int POS_W  = $clog2(NUM_COPIES * BYTES_PER_COPY + 1);
  localparam int MIDX_W = $clog2(BYTES_PER_COPY);
  localparam int GOOD_W = $clog2(BYTES_PER_COPY + 1);
  localparam int IDX_W  = (VALUE_BYTES > 1) ? $clog2(VALUE_BYTES) : 1;
  localparam logic [31:0] VAL_MASK = (VALUE_BYTES >= 4) ? 32'hFFFF_FFFF :
                                     32'((64'd1 << (8 * VALUE_BYTES)) - 64'd1);
  localparam logic [POS_W-1:0] POS_END  = POS_W'(BYTES_PER_COPY);
  localparam logic [POS_W-1:0] CLR_LAST = POS_W'(NUM_COPIES * BYTES_PER_COPY - 1);

  state_t state, state_next, launch_state;

  // captured item
  logic [1:0]            func_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [15:0]           fail_r;
  logic                  mfail_r;

  // working registers
  logic [SLOT_W-1:0]     slot;
  logic [1:0]            cp_r;
  logic [POS_W-1:0]      pos;
  logic [IDX_W-1:0]      bidx;
  logic [GOOD_W-1:0]     good;
  logic [31:0]           acc;
  stat_t                 stat_r;

  // per-counter active copy and per-copy bad-byte masks
  logic [1:0]                active [NUM_COUNTERS];
  logic [BYTES_PER_COPY-1:0] masks  [NSLOTS];

  // byte RAM
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;

  // decode
  logic              accept;
  logic              in_range;
  logic [CNT_W-1:0]  cnt_in;
  logic [1:0]        cp_in;
  logic [1:0]        cp_next;
  logic [SLOT_W-1:0] launch_slot;
  logic [MIDX_W-1:0] pos_idx;
  logic              at_end;
  logic              cur_bad;
  logic              last_byte;
  logic [7:0]        byte_want;
  logic              byte_eq;
  logic              byte_fail;

  assign accept   = start && !busy;
  assign in_range = 5'(counter_sel) < 5'(NUM_COUNTERS);
  assign cnt_in   = CNT_W'(counter_sel);
  assign cp_in    = (active[cnt_in] >= 2'(NUM_COPIES)) ? 2'd0 : active[cnt_in];
  assign cp_next  = (cp_r == 2'(NUM_COPIES - 1)) ? 2'd0 : cp_r + 2'd1;

  assign pos_idx   = pos[MIDX_W-1:0];
  assign at_end    = (pos == POS_END);
  assign cur_bad   = masks[slot][pos_idx];
  assign last_byte = (bidx == IDX_W'(VALUE_BYTES - 1));
  assign byte_want = acc[{bidx, 3'b000} +: 8];
  assign byte_eq   = (ram_rdata == byte_want);
  assign byte_fail = (pos < POS_W'(FAIL_BITS)) && fail_r[pos[3:0]];
  assign ram_addr  = ADDR_W'(slot) * ADDR_W'(BYTES_PER_COPY) + ADDR_W'(pos);

  // first state and slot of a new item
  always_comb begin
    launch_slot = SLOT_W'(cnt_in) * SLOT_W'(NUM_COPIES);
    if (!in_range) begin
      launch_state = S_FINISH;
    end else begin
      case (func)
        FN_GET, FN_INC: begin
          launch_state = S_RD_SCAN;
          launch_slot  = launch_slot + SLOT_W'(cp_in);
        end
        FN_CLR:  launch_state = S_CLR;
        default: launch_state = S_FINISH;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE, S_FINISH: begin
        state_next = accept ? launch_state : S_IDLE;
      end
      S_RD_SCAN: begin
        if (at_end) begin
          state_next = (func_r == FN_GET) ? S_FINISH : S_INC;
        end else if (!cur_bad) begin
          state_next = S_RD_WAIT;
        end
      end
      S_RD_WAIT: begin
        if (last_byte) begin
          state_next = (func_r == FN_GET) ? S_FINISH : S_INC;
        end else begin
          state_next = S_RD_SCAN;
        end
      end
      S_INC: state_next = S_CNT;
      S_CNT: begin
        if (at_end) begin
          state_next = (good < GOOD_W'(VALUE_BYTES)) ? S_FINISH : S_WR_SCAN;
        end
      end
      S_WR_SCAN: begin
        if (at_end) begin
          state_next = S_FINISH;
        end else if (!cur_bad) begin
          state_next = S_WR_CMP;
        end
      end
      S_WR_CMP: begin
        if (byte_eq || !byte_fail) begin
          state_next = last_byte ? S_FINISH : S_WR_SCAN;
        end else begin
          state_next = mfail_r ? S_FINISH : S_WR_SCAN;
        end
      end
      S_CLR: begin
        if (pos == CLR_LAST) begin
          state_next = S_FINISH;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and RAM control
  always_comb begin
    busy      = !(state == S_IDLE || state == S_FINISH);
    done      = (state == S_FINISH);
    ram_we    = 1'b0;
    ram_wdata = byte_want;
    case (state)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_wdata = 8'h00;
      end
      S_WR_CMP: ram_we = !byte_eq && !byte_fail;
      default: ram_we = 1'b0;
    endcase
  end

  assign value  = acc;
  assign status = stat_r;

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int c = 0; c < NUM_COUNTERS; c++) begin
        active[c] <= 2'd0;
      end
    end else begin
      state <= state_next;
      if (accept) begin
        func_r  <= func;
        cnt_r   <= cnt_in;
        fail_r  <= fail_positions;
        mfail_r <= mask_write_fails;
        cp_r    <= cp_in;
        slot    <= launch_slot;
        acc     <= 32'd0;
        stat_r  <= STAT_OK;
        pos     <= '0;
        bidx    <= '0;
      end else begin
        case (state)
          S_RD_SCAN: begin
            if (at_end) begin
              if (func_r == FN_GET) begin
                stat_r <= STAT_SHORT;
              end
            end else if (cur_bad) begin
              pos <= pos + 1'b1;
            end
          end
          S_RD_WAIT: begin
            acc[{bidx, 3'b000} +: 8] <= ram_rdata;
            bidx <= bidx + 1'b1;
            pos  <= pos + 1'b1;
          end
          S_INC: begin
            acc           <= (acc + 32'd1) & VAL_MASK;
            active[cnt_r] <= cp_next;
            cp_r          <= cp_next;
            slot          <= SLOT_W'(cnt_r) * SLOT_W'(NUM_COPIES) + SLOT_W'(cp_next);
            pos           <= '0;
            good          <= '0;
          end
          S_CNT: begin
            if (at_end) begin
              pos  <= '0;
              bidx <= '0;
              if (good < GOOD_W'(VALUE_BYTES)) begin
                stat_r <= STAT_SHORT;
              end
            end else begin
              good <= good + GOOD_W'(!cur_bad);
              pos  <= pos + 1'b1;
            end
          end
          S_WR_SCAN: begin
            if (at_end) begin
              stat_r <= STAT_SHORT;
            end else if (cur_bad) begin
              pos <= pos + 1'b1;
            end
          end
          S_WR_CMP: begin
            if (byte_eq || !byte_fail) begin
              bidx <= bidx + 1'b1;
              pos  <= pos + 1'b1;
            end else if (mfail_r) begin
              stat_r <= STAT_MASK;
            end else begin
              pos <= pos + 1'b1;
            end
          end
          S_CLR: pos <= pos + 1'b1;
          default: ;
        endcase
      end
    end
  end

  // bad-byte masks: cleared with the counter, marked on a failed write
  always_ff @(posedge clk) begin
    if (state == S_CLR && pos == '0) begin
      for (int s = 0; s < NSLOTS; s++) begin
        if (CNT_W'(s / NUM_COPIES) == cnt_r) begin
          masks[s] <= '0;
        end
      end
    end else if (state == S_WR_CMP && !byte_eq && byte_fail && !mfail_r) begin
      masks[slot][pos_idx] <= 1'b1;
    end
  end

  // counter byte store
  pcbbr_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_bytes (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_addr),
    .wdata(ram_wdata),
    .raddr(ram_addr),
    .rdata(ram_rdata)
  );

  // checks
  `PCBBR_ASSERT_IMP(a_done_not_busy, clk, rst, done, !busy)
  `PCBBR_ASSERT_NXT(a_accept_progress, clk, rst, start && !busy, busy || done)
  `PCBBR_ASSERT_IMP(a_write_in_item, clk, rst, ram_we, busy)
  `PCBBR_ASSERT_IMP(a_status_code, clk, rst, done, (status == STAT_OK) || (status == STAT_SHORT) || (status == STAT_MASK))

endmodule
`default_nettype wire
